>>> rtl/core/sti_pkg.sv
`default_nettype none
package sti_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int T_FRAC_BITS = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int CROSS_W     = 2 * DIFF_W + 1;
    localparam int PROD_W      = CROSS_W + DIFF_W;
    localparam int SUM_W       = PROD_W + 3;
    localparam int HD_W        = T_FRAC_BITS + 1;
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_END_X   = 3'd3,
        REG_END_Y   = 3'd4,
        REG_END_Z   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] v0_x;
        logic signed [COORD_WIDTH-1:0] v0_y;
        logic signed [COORD_WIDTH-1:0] v0_z;
        logic signed [COORD_WIDTH-1:0] v1_x;
        logic signed [COORD_WIDTH-1:0] v1_y;
        logic signed [COORD_WIDTH-1:0] v1_z;
        logic signed [COORD_WIDTH-1:0] v2_x;
        logic signed [COORD_WIDTH-1:0] v2_y;
        logic signed [COORD_WIDTH-1:0] v2_z;
    } tri_in_t;

    typedef struct packed {
        logic            hit;
        logic [HD_W-1:0] hit_distance;
    } hit_out_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
    } coord_vec_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
    } dvec_t;

    typedef struct packed {
        logic signed [CROSS_W-1:0] x;
        logic signed [CROSS_W-1:0] y;
        logic signed [CROSS_W-1:0] z;
    } cvec_t;

    typedef struct packed {
        dvec_t dir;
        dvec_t e1;
        dvec_t e2;
        dvec_t s;
    } edge_set_t;

    function automatic dvec_t vec_sub(coord_vec_t a, coord_vec_t b);
        dvec_t r;
        r.x = DIFF_W'(a.x) - DIFF_W'(b.x);
        r.y = DIFF_W'(a.y) - DIFF_W'(b.y);
        r.z = DIFF_W'(a.z) - DIFF_W'(b.z);
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/sti_mul.sv
`default_nettype none
module sti_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic signed [AW-1:0] a,
    input  wire logic signed [BW-1:0] b,
    output logic signed [AW+BW-1:0]   prod
);

    localparam int LO = AW / 2;
    localparam int HI = AW - LO;

    logic signed [LO+BW:0]      plo_reg;
    logic signed [HI+BW-1:0]    phi_reg;
    logic signed [AW+BW-1:0]    prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            plo_reg  <= $signed({1'b0, a[LO-1:0]}) * b;
            phi_reg  <= $signed(a[AW-1:LO]) * b;
            prod_reg <= $signed({phi_reg, {LO{1'b0}}}) + plo_reg;
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

>>> rtl/core/sti_front.sv
`default_nettype none
module sti_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire sti_pkg::tri_in_t   item,
    input  wire sti_pkg::coord_vec_t seg_start,
    input  wire sti_pkg::coord_vec_t seg_end,
    output logic                    out_valid,
    output sti_pkg::edge_set_t      edges,
    output sti_pkg::cvec_t          p,
    output sti_pkg::cvec_t          q
);

    sti_pkg::coord_vec_t v0, v1, v2;
    sti_pkg::edge_set_t  a_reg, d1_reg, d2_reg, c_reg;
    sti_pkg::cvec_t      p_reg, q_reg;
    logic                va_reg, v1_reg, v2_reg, vc_reg;

    logic signed [sti_pkg::DIFF_W-1:0]   ma [12];
    logic signed [sti_pkg::DIFF_W-1:0]   mb [12];
    logic signed [2*sti_pkg::DIFF_W-1:0] pr [12];

    assign v0 = '{x: item.v0_x, y: item.v0_y, z: item.v0_z};
    assign v1 = '{x: item.v1_x, y: item.v1_y, z: item.v1_z};
    assign v2 = '{x: item.v2_x, y: item.v2_y, z: item.v2_z};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            v1_reg <= va_reg;
            v2_reg <= v1_reg;
            vc_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg.dir <= sti_pkg::vec_sub(seg_end, seg_start);
            a_reg.e1  <= sti_pkg::vec_sub(v1, v0);
            a_reg.e2  <= sti_pkg::vec_sub(v2, v0);
            a_reg.s   <= sti_pkg::vec_sub(seg_start, v0);
            d1_reg    <= a_reg;
            d2_reg    <= d1_reg;
            c_reg     <= d2_reg;
            p_reg.x   <= sti_pkg::CROSS_W'(pr[0]) - sti_pkg::CROSS_W'(pr[1]);
            p_reg.y   <= sti_pkg::CROSS_W'(pr[2]) - sti_pkg::CROSS_W'(pr[3]);
            p_reg.z   <= sti_pkg::CROSS_W'(pr[4]) - sti_pkg::CROSS_W'(pr[5]);
            q_reg.x   <= sti_pkg::CROSS_W'(pr[6]) - sti_pkg::CROSS_W'(pr[7]);
            q_reg.y   <= sti_pkg::CROSS_W'(pr[8]) - sti_pkg::CROSS_W'(pr[9]);
            q_reg.z   <= sti_pkg::CROSS_W'(pr[10]) - sti_pkg::CROSS_W'(pr[11]);
        end
    end

    // p = dir x e2, q = s x e1
    always_comb begin
        ma[0]  = a_reg.dir.y; mb[0]  = a_reg.e2.z;
        ma[1]  = a_reg.dir.z; mb[1]  = a_reg.e2.y;
        ma[2]  = a_reg.dir.z; mb[2]  = a_reg.e2.x;
        ma[3]  = a_reg.dir.x; mb[3]  = a_reg.e2.z;
        ma[4]  = a_reg.dir.x; mb[4]  = a_reg.e2.y;
        ma[5]  = a_reg.dir.y; mb[5]  = a_reg.e2.x;
        ma[6]  = a_reg.s.y;   mb[6]  = a_reg.e1.z;
        ma[7]  = a_reg.s.z;   mb[7]  = a_reg.e1.y;
        ma[8]  = a_reg.s.z;   mb[8]  = a_reg.e1.x;
        ma[9]  = a_reg.s.x;   mb[9]  = a_reg.e1.z;
        ma[10] = a_reg.s.x;   mb[10] = a_reg.e1.y;
        ma[11] = a_reg.s.y;   mb[11] = a_reg.e1.x;
    end

    for (genvar i = 0; i < 12; i++) begin : g_mul
        sti_mul #(
            .AW(sti_pkg::DIFF_W),
            .BW(sti_pkg::DIFF_W)
        ) u_mul (
            .aclk(aclk),
            .en  (en),
            .a   (ma[i]),
            .b   (mb[i]),
            .prod(pr[i])
        );
    end

    assign out_valid = vc_reg;
    assign edges     = c_reg;
    assign p         = p_reg;
    assign q         = q_reg;

endmodule
`default_nettype wire

>>> rtl/core/sti_dot.sv
`default_nettype none
module sti_dot (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire sti_pkg::edge_set_t        edges,
    input  wire sti_pkg::cvec_t            p,
    input  wire sti_pkg::cvec_t            q,
    output logic                           out_valid,
    output logic                           hit,
    output logic [sti_pkg::SUM_W-1:0]      num,
    output logic [sti_pkg::SUM_W-1:0]      den
);

    localparam int SW = sti_pkg::SUM_W;

    logic signed [sti_pkg::CROSS_W-1:0] ma [12];
    logic signed [sti_pkg::DIFF_W-1:0]  mb [12];
    logic signed [sti_pkg::PROD_W-1:0]  pr [12];

    logic v1_reg, v2_reg, vs_reg, vn_reg, vk_reg;
    logic signed [SW-1:0] det_reg, u_reg, v_reg, t_reg;
    logic signed [SW-1:0] ndet_reg, nu_reg, nv_reg, nt_reg;
    logic signed [SW:0]   uv;
    logic                 hit_next;
    logic                 hit_reg;
    logic [SW-1:0]        num_reg, den_reg;

    always_comb begin
        ma[0]  = p.x; mb[0]  = edges.e1.x;
        ma[1]  = p.y; mb[1]  = edges.e1.y;
        ma[2]  = p.z; mb[2]  = edges.e1.z;
        ma[3]  = p.x; mb[3]  = edges.s.x;
        ma[4]  = p.y; mb[4]  = edges.s.y;
        ma[5]  = p.z; mb[5]  = edges.s.z;
        ma[6]  = q.x; mb[6]  = edges.dir.x;
        ma[7]  = q.y; mb[7]  = edges.dir.y;
        ma[8]  = q.z; mb[8]  = edges.dir.z;
        ma[9]  = q.x; mb[9]  = edges.e2.x;
        ma[10] = q.y; mb[10] = edges.e2.y;
        ma[11] = q.z; mb[11] = edges.e2.z;
    end

    for (genvar i = 0; i < 12; i++) begin : g_mul
        sti_mul #(
            .AW(sti_pkg::CROSS_W),
            .BW(sti_pkg::DIFF_W)
        ) u_mul (
            .aclk(aclk),
            .en  (en),
            .a   (ma[i]),
            .b   (mb[i]),
            .prod(pr[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vs_reg <= 1'b0;
            vn_reg <= 1'b0;
            vk_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            vs_reg <= v2_reg;
            vn_reg <= vs_reg;
            vk_reg <= vn_reg;
        end
    end

    assign uv = (SW + 1)'(nu_reg) + (SW + 1)'(nv_reg);

    // A zero determinant is a miss even when all bounds would pass.
    assign hit_next = (ndet_reg != '0) && !nu_reg[SW-1] && (nu_reg <= ndet_reg)
                      && !nv_reg[SW-1] && (uv <= (SW + 1)'(ndet_reg))
                      && !nt_reg[SW-1] && (nt_reg <= ndet_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg <= SW'(pr[0]) + SW'(pr[1]) + SW'(pr[2]);
            u_reg   <= SW'(pr[3]) + SW'(pr[4]) + SW'(pr[5]);
            v_reg   <= SW'(pr[6]) + SW'(pr[7]) + SW'(pr[8]);
            t_reg   <= SW'(pr[9]) + SW'(pr[10]) + SW'(pr[11]);
            if (det_reg[SW-1]) begin
                ndet_reg <= -det_reg;
                nu_reg   <= -u_reg;
                nv_reg   <= -v_reg;
                nt_reg   <= -t_reg;
            end else begin
                ndet_reg <= det_reg;
                nu_reg   <= u_reg;
                nv_reg   <= v_reg;
                nt_reg   <= t_reg;
            end
            hit_reg <= hit_next;
            num_reg <= nt_reg;
            den_reg <= ndet_reg;
        end
    end

    assign out_valid = vk_reg;
    assign hit       = hit_reg;
    assign num       = num_reg;
    assign den       = den_reg;

endmodule
`default_nettype wire

>>> rtl/core/sti_div.sv
`default_nettype none
module sti_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic                      hit,
    input  wire logic [sti_pkg::SUM_W-1:0] num,
    input  wire logic [sti_pkg::SUM_W-1:0] den,
    output logic                           out_valid,
    output sti_pkg::hit_out_t              result
);

    localparam int RW = sti_pkg::SUM_W + 1;
    localparam int NS = sti_pkg::T_FRAC_BITS + 1;

    logic [RW-1:0]               rem_reg [NS];
    logic [RW-1:0]               den_reg [NS];
    logic [sti_pkg::HD_W-1:0]    q_reg   [NS];
    logic                        hit_reg [NS];
    logic                        vld_reg [NS];

    // First stage takes the integer bit, every later stage one fraction bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0] <= RW'(den);
            hit_reg[0] <= hit;
            if (num >= den) begin
                rem_reg[0] <= RW'(num - den);
                q_reg[0]   <= sti_pkg::HD_W'(1);
            end else begin
                rem_reg[0] <= RW'(num);
                q_reg[0]   <= '0;
            end
        end
    end

    for (genvar i = 1; i < NS; i++) begin : g_step
        logic [RW-1:0] dbl;
        assign dbl = {rem_reg[i-1][RW-2:0], 1'b0};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[i] <= den_reg[i-1];
                hit_reg[i] <= hit_reg[i-1];
                if (dbl >= den_reg[i-1]) begin
                    rem_reg[i] <= dbl - den_reg[i-1];
                    q_reg[i]   <= {q_reg[i-1][sti_pkg::HD_W-2:0], 1'b1};
                end else begin
                    rem_reg[i] <= dbl;
                    q_reg[i]   <= {q_reg[i-1][sti_pkg::HD_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid           = vld_reg[NS-1];
    assign result.hit          = hit_reg[NS-1];
    assign result.hit_distance = hit_reg[NS-1] ? q_reg[NS-1] : '0;

endmodule
`default_nettype wire

>>> rtl/core/segment_triangle_intersect_top.sv
// Segment against triangle intersection test, both faces accepted.
// Write the segment end points through the cfg_wr_en / cfg_index / cfg_wr_data
// port while no transfer is in flight. Each transfer on the s_ channel carries
// one triangle; the m_ channel returns exactly one result per triangle, in
// order, with a hit flag and the segment parameter t (17 bits, 65536 is 1.0).
// The block is a fixed pipeline of 26 stages: 9 for the difference, cross and
// dot product arithmetic (multipliers split into two registered halves) and 17
// for the restoring divider that forms t one bit per stage. One triangle is
// taken every cycle as long as the receiver keeps m_ready high.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_ready drops; nothing is lost or repeated. Bubbles inside the pipeline are
// not squeezed out during a stall. Reset clears the pipeline valid bits and
// sets all segment coordinates to zero.
`default_nettype none
module segment_triangle_intersect_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire sti_pkg::tri_in_t                  s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output sti_pkg::hit_out_t                      m_data,
    input  wire logic                              cfg_wr_en,
    input  wire logic [sti_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sti_pkg::COORD_WIDTH-1:0]   cfg_wr_data
);

    sti_pkg::coord_vec_t seg_start_reg, seg_end_reg;
    sti_pkg::edge_set_t  edges;
    sti_pkg::cvec_t      p, q;
    logic                en;
    logic                fr_valid, dot_valid, dot_hit;
    logic [sti_pkg::SUM_W-1:0] num, den;

    // A stage moves whenever the output register is empty or being drained.
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_start_reg <= '0;
            seg_end_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sti_pkg::REG_START_X: seg_start_reg.x <= cfg_wr_data;
                sti_pkg::REG_START_Y: seg_start_reg.y <= cfg_wr_data;
                sti_pkg::REG_START_Z: seg_start_reg.z <= cfg_wr_data;
                sti_pkg::REG_END_X:   seg_end_reg.x   <= cfg_wr_data;
                sti_pkg::REG_END_Y:   seg_end_reg.y   <= cfg_wr_data;
                sti_pkg::REG_END_Z:   seg_end_reg.z   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    sti_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .item     (s_data),
        .seg_start(seg_start_reg),
        .seg_end  (seg_end_reg),
        .out_valid(fr_valid),
        .edges    (edges),
        .p        (p),
        .q        (q)
    );

    sti_dot u_dot (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (fr_valid),
        .edges    (edges),
        .p        (p),
        .q        (q),
        .out_valid(dot_valid),
        .hit      (dot_hit),
        .num      (num),
        .den      (den)
    );

    sti_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (dot_valid),
        .hit      (dot_hit),
        .num      (num),
        .den      (den),
        .out_valid(m_valid),
        .result   (m_data)
    );

endmodule
`default_nettype wire

>>> bench/tb_segment_triangle_intersect_top.sv
`default_nettype none
module tb_segment_triangle_intersect_top;
    import sti_pkg::*;

    typedef logic signed [127:0] wide_t;
    typedef wide_t vec3_t [3];
    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam coord_t ONE = 32'sd65536;
    localparam coord_t CMAX = 32'sh7fffffff;
    localparam coord_t CMIN = 32'sh80000000;
    localparam int STALL_LIMIT = 3000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    tri_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    hit_out_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_WIDTH-1:0] cfg_wr_data = '0;

    coord_t seg_cfg [6];
    tri_in_t pending_tris [$];
    hit_out_t expected_hits [$];
    int mismatches = 0;
    int results_seen = 0;
    int cycle_cnt = 0;
    int idle_cnt = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    segment_triangle_intersect_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic vec3_t vsub(vec3_t a, vec3_t b);
        vec3_t r;
        for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
        return r;
    endfunction

    function automatic vec3_t vcross(vec3_t a, vec3_t b);
        vec3_t r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    function automatic wide_t vdot(vec3_t a, vec3_t b);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic vec3_t widen(coord_t x, coord_t y, coord_t z);
        vec3_t r;
        r[0] = wide_t'(x);
        r[1] = wide_t'(y);
        r[2] = wide_t'(z);
        return r;
    endfunction

    function automatic hit_out_t predict_hit(tri_in_t t);
        vec3_t a, b, v0, dir, e1, e2, p, s, q;
        wide_t det, u, v, tt;
        hit_out_t r;
        a = widen(seg_cfg[REG_START_X], seg_cfg[REG_START_Y], seg_cfg[REG_START_Z]);
        b = widen(seg_cfg[REG_END_X], seg_cfg[REG_END_Y], seg_cfg[REG_END_Z]);
        v0 = widen(t.v0_x, t.v0_y, t.v0_z);
        dir = vsub(b, a);
        e1 = vsub(widen(t.v1_x, t.v1_y, t.v1_z), v0);
        e2 = vsub(widen(t.v2_x, t.v2_y, t.v2_z), v0);
        p = vcross(dir, e2);
        det = vdot(e1, p);
        r = '0;
        if (det == 0) return r;
        s = vsub(a, v0);
        q = vcross(s, e1);
        u = vdot(s, p);
        v = vdot(dir, q);
        tt = vdot(e2, q);
        if (det < 0) begin
            det = -det;
            u = -u;
            v = -v;
            tt = -tt;
        end
        if (u < 0 || u > det || v < 0 || u + v > det || tt < 0 || tt > det) return r;
        r.hit = 1'b1;
        r.hit_distance = HD_W'((tt <<< T_FRAC_BITS) / det);
        return r;
    endfunction

    function automatic tri_in_t make_tri(coord_t ax, coord_t ay, coord_t az,
                                         coord_t bx, coord_t by, coord_t bz,
                                         coord_t cx, coord_t cy, coord_t cz);
        tri_in_t t;
        t.v0_x = ax; t.v0_y = ay; t.v0_z = az;
        t.v1_x = bx; t.v1_y = by; t.v1_z = bz;
        t.v2_x = cx; t.v2_y = cy; t.v2_z = cz;
        return t;
    endfunction

    function automatic coord_t jitter(int span);
        return coord_t'($urandom_range(2 * span, 0)) - coord_t'(span);
    endfunction

    // Triangles placed around a random point of the segment, so many of them hit.
    function automatic tri_in_t aimed_tri();
        coord_t px, py, pz;
        int k, span;
        tri_in_t t;
        k = $urandom_range(16, 0);
        px = seg_cfg[0] + coord_t'((longint'(seg_cfg[3]) - seg_cfg[0]) * k / 16);
        py = seg_cfg[1] + coord_t'((longint'(seg_cfg[4]) - seg_cfg[1]) * k / 16);
        pz = seg_cfg[2] + coord_t'((longint'(seg_cfg[5]) - seg_cfg[2]) * k / 16);
        span = 1 << $urandom_range(22, 2);
        t = make_tri(px + jitter(span), py + jitter(span), pz + jitter(span),
                     px + jitter(span), py + jitter(span), pz + jitter(span),
                     px + jitter(span), py + jitter(span), pz + jitter(span));
        if ($urandom_range(3, 0) == 0) t.v2_x = t.v0_x;
        return t;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, coord_t val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        if (idx <= REG_END_Z) seg_cfg[idx] = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_segment(coord_t sx, coord_t sy, coord_t sz,
                               coord_t ex, coord_t ey, coord_t ez);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_START_Z, sz);
        write_reg(REG_END_X, ex);
        write_reg(REG_END_Y, ey);
        write_reg(REG_END_Z, ez);
    endtask

    task automatic drain();
        while (pending_tris.size() != 0 || s_valid || expected_hits.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic random_batch(int count);
        tri_in_t t;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9, 0) < 8) begin
                t = aimed_tri();
            end else begin
                t = tri_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom});
            end
            pending_tris.push_back(t);
        end
    endtask

    function automatic coord_t rand_coord();
        return coord_t'($urandom_range(1 << 28, 0)) - coord_t'(1 << 27);
    endfunction

    always @(posedge aclk) begin
        logic next_valid;
        tri_in_t next_data;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            next_data = s_data;
            if (s_valid && s_ready) begin
                expected_hits.push_back(predict_hit(s_data));
                next_valid = 1'b0;
            end
            if (!next_valid && pending_tris.size() != 0) begin
                if ((cycle_cnt % 5000) < 1500 || $urandom_range(99, 0) >= 15) begin
                    next_data = pending_tris.pop_front();
                    next_valid = 1'b1;
                end
            end
            s_valid <= next_valid;
            s_data <= next_data;
        end
    end

    always @(posedge aclk) begin
        hit_out_t want;
        cycle_cnt <= cycle_cnt + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_hits.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result %p", m_data);
                end else begin
                    want = expected_hits.pop_front();
                    if (want.hit !== m_data.hit || want.hit_distance !== m_data.hit_distance) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("result mismatch: expected hit=%0d t=%0d, got hit=%0d t=%0d",
                                     want.hit, want.hit_distance, m_data.hit, m_data.hit_distance);
                    end
                end
            end
            // One long receiver hold while the sender keeps offering triangles.
            if (!hold_done && results_seen == 600) begin
                hold_done <= 1'b1;
                hold_left <= 400;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ((cycle_cnt % 5000) < 1500) || ($urandom_range(99, 0) >= 15);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cnt <= 0;
            else if (pending_tris.size() != 0 || s_valid || expected_hits.size() != 0)
                idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        seg_cfg = '{default: '0};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset segment is a single point, so every triangle misses.
        pending_tris.push_back(make_tri(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, 0));
        pending_tris.push_back(make_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, ONE));
        drain();

        // Segment along z through the origin, crossing the plane z = 0 at t = 0.5.
        set_segment(0, 0, -ONE, 0, 0, ONE);
        write_reg(REG_SPARE_LO, CMAX);
        write_reg(REG_SPARE_HI, CMIN);
        pending_tris.push_back(make_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0));
        pending_tris.push_back(make_tri(-ONE, -ONE, 0, 0, ONE, 0, ONE, -ONE, 0));
        pending_tris.push_back(make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        pending_tris.push_back(make_tri(-ONE, 0, 0, ONE, 0, 0, 0, ONE, 0));
        pending_tris.push_back(make_tri(-ONE, 1, 0, ONE, 1, 0, 0, ONE, 0));
        pending_tris.push_back(make_tri(-ONE, -ONE, -ONE, ONE, -ONE, -ONE, 0, ONE, -ONE));
        pending_tris.push_back(make_tri(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE));
        pending_tris.push_back(make_tri(-ONE, -ONE, ONE + 1, ONE, -ONE, ONE + 1, 0, ONE, ONE + 1));
        pending_tris.push_back(make_tri(-ONE, -ONE, -ONE, ONE, ONE, ONE, -ONE, ONE, ONE));
        pending_tris.push_back(make_tri(0, -ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE));
        pending_tris.push_back(make_tri(ONE, ONE, 0, ONE, ONE, 0, ONE, ONE, 0));
        pending_tris.push_back(make_tri(CMIN, CMIN, 0, CMAX, CMIN, 0, 0, CMAX, 0));
        pending_tris.push_back(make_tri(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX));
        drain();

        set_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        pending_tris.push_back(make_tri(CMIN, CMAX, 0, CMAX, CMIN, 0, CMAX, CMAX, 0));
        pending_tris.push_back(make_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN));
        pending_tris.push_back(make_tri(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX));
        random_batch(150);
        drain();

        set_segment(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
        random_batch(100);
        drain();

        set_segment(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE);
        random_batch(50);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            set_segment(rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord());
            random_batch(340);
            drain();
        end

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
